### rtl/prt_pkg.sv
// Shared types and constants of the prescaled reload timer bank.
// Used by every other file of the block but prt_min_tree; depends on nothing.
package prt_pkg;

	localparam int DATA_W         = 32;
	localparam int CMD_W          = 2;
	localparam int IRQ_W          = 4;
	localparam int CTRL_W         = 9;
	localparam int PADDR_W        = 5;
	localparam int NUM_REG_TIMERS = 3;

	// Entry of the reload array and bit of irq_fired that belong to the system tick.
	localparam int SYS_IDX        = 3;

	// Control register layout.
	localparam int CTRL_EN_LSB    = 0;
	localparam int CTRL_IRQ_LSB   = 4;
	localparam int SYS_EN_BIT     = 3;
	localparam int SYS_IRQ_BIT    = 7;
	localparam int GLOBAL_IRQ_BIT = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_SKIP  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_e;

	typedef enum logic [2:0] {
		REG_T0_RELOAD  = 3'd0,
		REG_T1_RELOAD  = 3'd1,
		REG_T2_RELOAD  = 3'd2,
		REG_SYS_RELOAD = 3'd3,
		REG_T0_PSC     = 3'd4,
		REG_T1_PSC     = 3'd5,
		REG_T2_PSC     = 3'd6,
		REG_CTRL       = 3'd7
	} reg_idx_e;

	typedef struct packed {
		logic [CTRL_W-1:0]                          ctrl;
		logic [NUM_REG_TIMERS-1:0][DATA_W-1:0]      prescaler;
		logic [NUM_REG_TIMERS:0][DATA_W-1:0]        reload;
	} cfg_t;

	// Operation broadcast to every counter for the item in stage one.
	typedef struct packed {
		logic              fire;
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] count;
	} ctr_op_t;

endpackage

### rtl/prt_cmd_if.sv
// Command channel of the timer bank: valid/ready plus command and count.
// Depends on prt_pkg for field widths.
interface prt_cmd_if import prt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [DATA_W-1:0] count;

	modport source (output valid, output command, output count, input ready);
	modport sink (input valid, input command, input count, output ready);
endinterface

### rtl/prt_res_if.sv
// Result channel of the timer bank: valid/ready plus irq_fired and ticks_free.
// Depends on prt_pkg for field widths.
interface prt_res_if import prt_pkg::*;;
	logic              valid;
	logic              ready;
	logic [IRQ_W-1:0]  irq_fired;
	logic [DATA_W-1:0] ticks_free;

	modport source (output valid, output irq_fired, output ticks_free, input ready);
	modport sink (input valid, input irq_fired, input ticks_free, output ready);
endinterface

### rtl/prt_apb_regs.sv
// APB-style configuration registers: reloads, prescalers and control bits.
// Depends on prt_pkg for the register map and cfg_t.
module prt_apb_regs import prt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_e idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_T0_RELOAD:  cfg_q.reload[0]    <= pwdata;
				REG_T1_RELOAD:  cfg_q.reload[1]    <= pwdata;
				REG_T2_RELOAD:  cfg_q.reload[2]    <= pwdata;
				REG_SYS_RELOAD: cfg_q.reload[3]    <= pwdata;
				REG_T0_PSC:     cfg_q.prescaler[0] <= pwdata;
				REG_T1_PSC:     cfg_q.prescaler[1] <= pwdata;
				REG_T2_PSC:     cfg_q.prescaler[2] <= pwdata;
				REG_CTRL:       cfg_q.ctrl         <= pwdata[CTRL_W-1:0];
				default:        cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_T0_RELOAD:  prdata = cfg_q.reload[0];
			REG_T1_RELOAD:  prdata = cfg_q.reload[1];
			REG_T2_RELOAD:  prdata = cfg_q.reload[2];
			REG_SYS_RELOAD: prdata = cfg_q.reload[3];
			REG_T0_PSC:     prdata = cfg_q.prescaler[0];
			REG_T1_PSC:     prdata = cfg_q.prescaler[1];
			REG_T2_PSC:     prdata = cfg_q.prescaler[2];
			REG_CTRL:       prdata = DATA_W'(cfg_q.ctrl);
			default:        prdata = '0;
		endcase
	end

endmodule

### rtl/prt_down_ctr.sv
// One down-counting timer: optional prescaler plus reloading main counter.
// Depends on prt_pkg for ctr_op_t and the command codes.
module prt_down_ctr import prt_pkg::*; #(
	parameter int CW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctr_op_t           op,
	input  logic              on,
	input  logic              irq_on,
	input  logic [CW-1:0]     reload,
	input  logic [CW-1:0]     psc,
	output logic              fired,
	output logic [DATA_W-1:0] cand
);

	logic [CW-1:0]     pc_q, mc_q, pc_nxt, mc_nxt;
	logic [DATA_W-1:0] pc_ext, mc_ext;
	logic              psc_nz, pc_le1, main_step, hit;

	assign psc_nz    = |psc;
	assign pc_le1    = (pc_q <= CW'(1));
	// main counter moves on every tick, or only when the prescaler wraps
	assign main_step = !psc_nz || pc_le1;
	assign hit       = main_step && (mc_q == CW'(1));
	assign pc_ext    = DATA_W'(pc_q);
	assign mc_ext    = DATA_W'(mc_q);

	always_comb begin
		pc_nxt = pc_q;
		mc_nxt = mc_q;
		case (op.cmd)
			CMD_TICK: begin
				if (psc_nz) pc_nxt = pc_le1 ? psc : pc_q - CW'(1);
				if (main_step) mc_nxt = (mc_q <= CW'(1)) ? reload : mc_q - CW'(1);
			end
			CMD_SKIP: begin
				// a counter the skip would reach or pass is left alone
				if (psc_nz) begin
					if (pc_ext > op.count) pc_nxt = CW'(pc_ext - op.count);
				end else if (mc_ext > op.count) begin
					mc_nxt = CW'(mc_ext - op.count);
				end
			end
			default: begin
				pc_nxt = pc_q;
				mc_nxt = mc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			mc_q <= '0;
		end else if (op.fire && on) begin
			pc_q <= pc_nxt;
			mc_q <= mc_nxt;
		end
	end

	assign fired = on && irq_on && hit && (op.cmd == CMD_TICK);

	// Event-free ticks this counter allows; op.count stands for no limit.
	always_comb begin
		if (!on) begin
			cand = op.count;
		end else if (psc_nz) begin
			cand = (pc_q != '0) ? DATA_W'(pc_q - CW'(1)) : '0;
		end else if (mc_q != '0) begin
			cand = DATA_W'(mc_q - CW'(1));
		end else begin
			cand = (reload != '0) ? '0 : op.count;
		end
	end

endmodule

### rtl/prt_min_tree.sv
// Balanced minimum tree over N unsigned values, built by recursive halving.
// Self-contained; no package needed.
module prt_min_tree #(
	parameter int N = 2,
	parameter int W = 32
) (
	input  logic [N-1:0][W-1:0] vals,
	output logic [W-1:0]        min_val
);

	if (N == 1) begin : g_leaf
		assign min_val = vals[0];
	end else begin : g_split
		localparam int NLo = N / 2;
		localparam int NHi = N - NLo;

		logic [W-1:0] lo_min, hi_min;

		prt_min_tree #(.N(NLo), .W(W)) u_lo (
			.vals    (vals[NLo-1:0]),
			.min_val (lo_min)
		);
		prt_min_tree #(.N(NHi), .W(W)) u_hi (
			.vals    (vals[N-1:NLo]),
			.min_val (hi_min)
		);

		assign min_val = (hi_min < lo_min) ? hi_min : lo_min;
	end

endmodule

### rtl/prescaled_reload_timer_bank_core.sv
// Top level of the prescaled reload timer bank: general timers, system tick,
// config registers. Depends on prt_pkg, prt_cmd_if, prt_res_if, prt_apb_regs,
// prt_down_ctr and prt_min_tree.
//
// Usage:
//  - cmd carries one item per valid/ready handshake: a single tick, a skip of
//    count event-free ticks, or a query for the ticks left before the next
//    event, capped at count. res returns exactly one item per command item,
//    in order: irq_fired (bit per timer, bit 3 system tick) and ticks_free.
//  - The APB port writes and reads the reload, prescaler and control
//    registers; write them only while no item is in flight.
//  - Flow: an accepted item sits in the input register; as it leaves that
//    register it moves the counters and its result is registered, which
//    raises res.valid. Throughput is one item per cycle while results are
//    taken, set by the counter update and query minimum.
//  - Stalls: the input register holds while the result register is full and
//    not taken, so up to two items wait in the block before cmd.ready drops;
//    a result taken in the same cycle lets a new item in at once.
//  - Reset clears the counters, config registers and valid flags only.
module prescaled_reload_timer_bank_core import prt_pkg::*; #(
	parameter int NUM_TIMERS  = 3,
	parameter int COUNT_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	prt_cmd_if.sink            cmd,
	prt_res_if.source          res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	// Timers past the register map never run, so they get no hardware.
	localparam int NumPhys = (NUM_TIMERS < NUM_REG_TIMERS) ? NUM_TIMERS : NUM_REG_TIMERS;
	// Candidates: general timers, system tick, and the query cap itself.
	localparam int NumCand = NumPhys + 2;

	cfg_t cfg;

	prt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the input register moves when the result register has room.
	logic in_ready, s1_adv;
	logic s1_valid_q, res_valid_q;

	assign s1_adv   = s1_valid_q && (!res_valid_q || res.ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign cmd.ready = in_ready;

	// Stage one: input register.
	logic [CMD_W-1:0]  command_s1;
	logic [DATA_W-1:0] count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && in_ready) begin
			command_s1 <= cmd.command;
			count_s1   <= cmd.count;
		end
	end

	// Counters commit the item's effect as it leaves stage one.
	ctr_op_t                        op;
	logic [NumPhys-1:0]             tmr_fired;
	logic                           sys_fired;
	logic [NumCand-1:0][DATA_W-1:0] cand;
	logic [IRQ_W-1:0]               fired_vec;
	logic                           global_irq;
	logic [DATA_W-1:0]              min_val;

	assign op.fire  = s1_adv;
	assign op.cmd   = command_s1;
	assign op.count = count_s1;
	assign global_irq = cfg.ctrl[GLOBAL_IRQ_BIT];

	for (genvar i = 0; i < NumPhys; i++) begin : g_tmr
		prt_down_ctr #(.CW(COUNT_WIDTH)) u_tmr (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.on     (cfg.ctrl[CTRL_EN_LSB + i]),
			.irq_on (cfg.ctrl[CTRL_IRQ_LSB + i] && global_irq),
			.reload (cfg.reload[i][COUNT_WIDTH-1:0]),
			.psc    (cfg.prescaler[i][COUNT_WIDTH-1:0]),
			.fired  (tmr_fired[i]),
			.cand   (cand[i])
		);
	end

	// System tick: same counter with the prescaler held off.
	prt_down_ctr #(.CW(COUNT_WIDTH)) u_sys (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.on     (cfg.ctrl[SYS_EN_BIT]),
		.irq_on (cfg.ctrl[SYS_IRQ_BIT] && global_irq),
		.reload (cfg.reload[SYS_IDX][COUNT_WIDTH-1:0]),
		.psc    ({COUNT_WIDTH{1'b0}}),
		.fired  (sys_fired),
		.cand   (cand[NumPhys])
	);

	assign cand[NumCand-1] = count_s1;

	always_comb begin
		fired_vec = '0;
		for (int i = 0; i < NumPhys; i++) begin
			fired_vec[i] = tmr_fired[i];
		end
		fired_vec[SYS_IDX] = sys_fired;
	end

	// Smallest bound wins; the cap is one of the candidates.
	prt_min_tree #(.N(NumCand), .W(DATA_W)) u_min (
		.vals    (cand),
		.min_val (min_val)
	);

	// Result register.
	logic [IRQ_W-1:0]  irq_q;
	logic [DATA_W-1:0] free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || res.ready) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			irq_q  <= fired_vec;
			free_q <= (command_s1 == CMD_QUERY) ? min_val : '0;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.irq_fired  = irq_q;
	assign res.ticks_free = free_q;

`ifndef ASSERT_OFF
	// An item leaving stage one always lands in the result register.
	a_s1_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> res_valid_q)
		else $error("item lost between stage one and the result register");

	// A query answer never exceeds its cap.
	a_query_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (command_s1 == CMD_QUERY)) |=> (res.ticks_free <= $past(count_s1)))
		else $error("query answer above its maximum");

	// Anything but a query answers zero.
	a_nonquery_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (command_s1 != CMD_QUERY)) |=> (res.ticks_free == '0))
		else $error("nonzero ticks_free for a non-query item");

	// Interrupts and query answers never share one result.
	a_irq_xor_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.irq_fired == '0 || res.ticks_free == '0))
		else $error("interrupt bits on a query result");
`endif

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for prescaled_reload_timer_bank_core: a directed table, then random phases.
// Depends on prt_pkg, prt_cmd_if, prt_res_if and the core RTL.
module tb;
	import prt_pkg::*;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 10;
	localparam int SETTLE_CYCLES   = 4;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int CYCLE_LIMIT     = 300000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [DATA_W-1:0] ALL_ONES  = '1;

	typedef struct {
		logic [IRQ_W-1:0]  irq;
		logic [DATA_W-1:0] free;
	} bank_result_t;

	// One line of the directed script: a register write or an item,
	// optionally with its result typed in.
	typedef struct {
		bit                is_reg;
		reg_idx_e          idx;
		logic [DATA_W-1:0] data;
		logic [CMD_W-1:0]  op;
		logic [DATA_W-1:0] n;
		bit                known;
		logic [IRQ_W-1:0]  irq;
		logic [DATA_W-1:0] free;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata, prdata;

	prt_cmd_if cmd_ch ();
	prt_res_if res_ch ();

	prescaled_reload_timer_bank_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mirror of the bank: registers and counters. Entry SYS_IDX is the system
	// tick, which has no prescaler, so its divider entries stay zero.
	logic [DATA_W-1:0] span_load [0:SYS_IDX];
	logic [DATA_W-1:0] div_load  [0:SYS_IDX];
	logic [CTRL_W-1:0] bank_ctrl;
	logic [DATA_W-1:0] div_left  [0:SYS_IDX];
	logic [DATA_W-1:0] ctr_left  [0:SYS_IDX];

	bank_result_t results_due [$];
	script_row_t  script [$];

	// Typed-in result that travels with the item on the command channel.
	bit                row_known;
	logic [IRQ_W-1:0]  row_irq;
	logic [DATA_W-1:0] row_free;

	int errors = 0;
	int cycles = 0;
	int send_calm = 0;
	int n_tick = 0, n_skip = 0, n_query = 0, n_unused = 0, n_fired = 0, n_settings = 0;

	// Advance the mirror by one item and return the result it must produce.
	function automatic bank_result_t advance_timers(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] n);
		bank_result_t r;
		logic [DATA_W-1:0] t;
		logic en, irq_en;
		bit step;
		r.irq  = '0;
		r.free = (op == CMD_QUERY) ? n : '0;
		for (int i = 0; i <= SYS_IDX; i++) begin
			en     = (i == SYS_IDX) ? bank_ctrl[SYS_EN_BIT] : bank_ctrl[CTRL_EN_LSB + i];
			irq_en = (i == SYS_IDX) ? bank_ctrl[SYS_IRQ_BIT] : bank_ctrl[CTRL_IRQ_LSB + i];
			if (!en)
				continue;
			case (op)
				CMD_TICK: begin
					step = 1'b1;
					// Prescaler: a zero count loads and lets the main counter move,
					// otherwise only the reload at one does.
					if (div_load[i] != 0) begin
						if (div_left[i] == 0) begin
							div_left[i] = div_load[i];
						end else if (div_left[i] == 1) begin
							div_left[i] = div_load[i];
						end else begin
							div_left[i] = div_left[i] - 1;
							step = 1'b0;
						end
					end
					if (step) begin
						if (ctr_left[i] == 0) begin
							ctr_left[i] = span_load[i];
						end else if (ctr_left[i] == 1) begin
							ctr_left[i] = span_load[i];
							r.irq[i] = irq_en && bank_ctrl[GLOBAL_IRQ_BIT];
						end else begin
							ctr_left[i] = ctr_left[i] - 1;
						end
					end
				end
				CMD_SKIP: begin
					// A counter that the skip would reach or pass is left alone.
					if (div_load[i] != 0) begin
						if (div_left[i] > n)
							div_left[i] = div_left[i] - n;
					end else if (ctr_left[i] > n) begin
						ctr_left[i] = ctr_left[i] - n;
					end
				end
				CMD_QUERY: begin
					if (div_load[i] != 0)
						t = (div_left[i] != 0) ? div_left[i] - 1 : '0;
					else if (ctr_left[i] != 0)
						t = ctr_left[i] - 1;
					else
						t = (span_load[i] != 0) ? '0 : n;   // idle timer never limits
					if (t < r.free)
						r.free = t;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	function automatic script_row_t reg_row(input reg_idx_e idx, input logic [DATA_W-1:0] v);
		script_row_t s;
		s.is_reg = 1'b1;
		s.idx    = idx;
		s.data   = v;
		s.known  = 1'b0;
		return s;
	endfunction

	function automatic script_row_t item_row(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] n);
		script_row_t s;
		s.is_reg = 1'b0;
		s.op     = op;
		s.n      = n;
		s.known  = 1'b0;
		return s;
	endfunction

	function automatic script_row_t known_row(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] n, input logic [IRQ_W-1:0] irq,
			input logic [DATA_W-1:0] free);
		script_row_t s;
		s       = item_row(op, n);
		s.known = 1'b1;
		s.irq   = irq;
		s.free  = free;
		return s;
	endfunction

	// Mostly short gaps, a few long ones, and now and then a calm stretch.
	function automatic int pick_gap();
		int r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			send_calm = $urandom_range(20, 60);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Reload, prescaler, skip and query values: small ones dominate so events
	// actually happen, with zero, all-ones and full-range values mixed in.
	function automatic logic [DATA_W-1:0] pick_span(input int zero_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return '0;
		if (r < zero_pct + 50)
			return $urandom_range(1, 8);
		if (r < zero_pct + 62)
			return ALL_ONES;
		return $urandom;
	endfunction

	// Present one item and hold it until accepted. Valid stays high across
	// back-to-back items.
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] n,
			input bit known, input logic [IRQ_W-1:0] irq, input logic [DATA_W-1:0] free);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.count   <= n;
		row_known      <= known;
		row_irq        <= irq;
		row_free       <= free;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every result is back and the pipe is quiet.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register over APB, update the mirror, then read it back.
	task automatic write_register(input reg_idx_e idx, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] want, got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		want = v;
		if (idx == REG_CTRL) begin
			bank_ctrl = v[CTRL_W-1:0];
			want      = DATA_W'(v[CTRL_W-1:0]);
		end else if (idx <= REG_SYS_RELOAD) begin
			span_load[idx - REG_T0_RELOAD] = v;
		end else begin
			div_load[idx - REG_T0_PSC] = v;
		end
		// Read back: new setup phase at the same address.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want) begin
			errors++;
			$display("%0t: register %s read back: expected %h, actual %h",
				$time, idx.name(), want, got);
		end
		// Leave the bus idle before the next transfer.
		@(posedge clk);
	endtask

	// Predict on every accepted item; a typed-in row overrides the mirror's
	// answer but the mirror still advances.
	always @(posedge clk) begin
		bank_result_t due;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			due = advance_timers(cmd_ch.command, cmd_ch.count);
			if (row_known) begin
				due.irq  = row_irq;
				due.free = row_free;
			end
			results_due.push_back(due);
			case (cmd_ch.command)
				CMD_TICK:  n_tick++;
				CMD_SKIP:  n_skip++;
				CMD_QUERY: n_query++;
				default:   n_unused++;
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		bank_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: irq_fired %h ticks_free %h",
					$time, res_ch.irq_fired, res_ch.ticks_free);
			end else begin
				want = results_due.pop_front();
				if (res_ch.irq_fired != 0)
					n_fired++;
				if (res_ch.irq_fired !== want.irq) begin
					errors++;
					$display("%0t: irq_fired mismatch: expected %h, actual %h",
						$time, want.irq, res_ch.irq_fired);
				end
				if (res_ch.ticks_free !== want.free) begin
					errors++;
					$display("%0t: ticks_free mismatch: expected %h, actual %h",
						$time, want.free, res_ch.ticks_free);
				end
			end
		end
	end

	// Result side: hold ready high most of the time, with short and long
	// stalls and occasional calm stretches.
	initial begin
		int r, hold, calm;
		bit rdy;
		hold = 0;
		calm = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (calm > 0) begin
				calm--;
				rdy = 1'b1;
			end else if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else begin
				r   = $urandom_range(0, 99);
				rdy = 1'b1;
				if (r < 3) begin
					calm = $urandom_range(20, 60);
				end else if (r < 25) begin
					rdy  = 1'b0;
					hold = $urandom_range(0, 2);
				end else if (r < 29) begin
					rdy  = 1'b0;
					hold = $urandom_range(5, 25);
				end
			end
			res_ch.ready <= rdy;
		end
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, results_due.size());
			$display("** prescaled_reload_timer_bank_core: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [CMD_W-1:0]  op;
		logic [DATA_W-1:0] v, n;
		int r;

		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.command = CMD_TICK;
		cmd_ch.count   = '0;
		row_known      = 1'b0;
		row_irq        = '0;
		row_free       = '0;
		bank_ctrl      = '0;
		for (int i = 0; i <= SYS_IDX; i++) begin
			span_load[i] = '0;
			div_load[i]  = '0;
			div_left[i]  = '0;
			ctr_left[i]  = '0;
		end

		// Directed script. Right after reset every timer is off: nothing fires,
		// the query returns its cap, and the unused command and skips do nothing.
		script.push_back(known_row(CMD_TICK,   '0,         '0, '0));
		script.push_back(known_row(CMD_QUERY,  ALL_ONES,   '0, ALL_ONES));
		script.push_back(known_row(CMD_QUERY,  '0,         '0, '0));
		script.push_back(known_row(CMD_UNUSED, ALL_ONES,   '0, '0));
		script.push_back(known_row(CMD_SKIP,   '0,         '0, '0));
		script.push_back(known_row(CMD_SKIP,   ALL_ONES,   '0, '0));
		// Enable everything: timer 1 divides by two, timer 2 is at full range,
		// the system tick reloads to one and fires on every tick once loaded.
		script.push_back(reg_row(REG_T0_RELOAD,  32'd3));
		script.push_back(reg_row(REG_T1_RELOAD,  32'd2));
		script.push_back(reg_row(REG_T2_RELOAD,  ALL_ONES));
		script.push_back(reg_row(REG_SYS_RELOAD, 32'd1));
		script.push_back(reg_row(REG_T0_PSC,     32'd0));
		script.push_back(reg_row(REG_T1_PSC,     32'd2));
		script.push_back(reg_row(REG_T2_PSC,     32'd0));
		script.push_back(reg_row(REG_CTRL,       32'h1ff));
		// Zero counters with nonzero reload bound the query at zero; the
		// first tick only loads, the second fires the system tick.
		script.push_back(known_row(CMD_QUERY, 32'd100, '0, '0));
		script.push_back(known_row(CMD_TICK,  '0,      '0, '0));
		script.push_back(known_row(CMD_TICK,  '0,      4'b1000, '0));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_QUERY, ALL_ONES));
		script.push_back(item_row(CMD_SKIP,  32'd1));
		script.push_back(item_row(CMD_QUERY, 32'hffff));
		script.push_back(item_row(CMD_TICK,  ALL_ONES));
		script.push_back(item_row(CMD_SKIP,  ALL_ONES));
		script.push_back(item_row(CMD_SKIP,  32'h8000_0000));
		script.push_back(item_row(CMD_TICK,  '0));
		// Largest prescaler, then global interrupt enable off.
		script.push_back(reg_row(REG_T2_PSC, ALL_ONES));
		script.push_back(reg_row(REG_CTRL,   32'h0ff));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_QUERY, ALL_ONES));
		// Global enable on but every per-timer interrupt enable off.
		script.push_back(reg_row(REG_CTRL,   32'h10f));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_TICK,  '0));
		script.push_back(item_row(CMD_QUERY, 32'd5));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_reg) begin
				wait_drained();
				write_register(script[k].idx, script[k].data);
				n_settings++;
			end else begin
				send_item(script[k].op, script[k].n, script[k].known,
					script[k].irq, script[k].free);
			end
		end

		// Random phases: phase zero puts every register at its maximum, phase
		// one leaves all timers enabled but idle, the rest draw settings.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			for (int k = REG_T0_RELOAD; k <= REG_CTRL; k++) begin
				if (ph == 0)
					v = ALL_ONES;
				else if (k == REG_CTRL && ph == 1)
					v = 32'h1ff;
				else if (ph == 1)
					v = '0;
				else if (k == REG_CTRL) begin
					v = $urandom_range(0, 511);
					if ($urandom_range(0, 3) != 0)
						v[GLOBAL_IRQ_BIT] = 1'b1;
				end else if (k >= REG_T0_PSC)
					v = pick_span(45);
				else
					v = pick_span(10);
				write_register(reg_idx_e'(k), v);
			end
			n_settings++;
			for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					op = CMD_TICK;
					n  = $urandom;
				end else if (r < 65) begin
					op = CMD_SKIP;
					n  = pick_span(10);
				end else if (r < 95) begin
					op = CMD_QUERY;
					n  = pick_span(10);
				end else begin
					op = CMD_UNUSED;
					n  = $urandom;
				end
				send_item(op, n, 1'b0, '0, '0);
			end
		end

		wait_drained();
		$display("Ran %0d ticks, %0d skips, %0d queries and %0d unused commands",
			n_tick, n_skip, n_query, n_unused);
		$display("over %0d register settings; %0d results raised interrupts.",
			n_settings, n_fired);
		if (errors == 0) begin
			$display("** prescaled_reload_timer_bank_core: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** prescaled_reload_timer_bank_core: FAILED **");
		end
		$finish;
	end

endmodule

### prescaled_reload_timer_bank_core.f
rtl/prt_pkg.sv
rtl/prt_cmd_if.sv
rtl/prt_res_if.sv
rtl/prt_apb_regs.sv
rtl/prt_down_ctr.sv
rtl/prt_min_tree.sv
rtl/prescaled_reload_timer_bank_core.sv
bench/tb.sv
